/* src/chpi_pkg.sv */
package chpi_pkg;

	localparam int TABLE_SLOTS_DEF = 256;
	localparam int NAME_BYTES_DEF = 8;
	localparam int TYPE_BYTES_DEF = 3;
	localparam logic [3:0] SIZE_LOG2_RESET = 4'd4;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;
	localparam logic KEY_NAME = 1'b0;
	localparam logic KEY_ID = 1'b1;

	localparam logic [0:0] REG_SIZE_LOG2 = 1'b0;

	typedef struct packed {
		logic        req_type;
		logic        key_kind;
		logic [23:0] type_chars;
		logic [1:0]  type_len;
		logic [63:0] name_chars;
		logic [3:0]  name_len;
		logic [31:0] res_id;
		logic [7:0]  entry_index;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [7:0] slot;
		logic [7:0] found_entry;
		logic       table_full;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic crc_step;
		logic probe_start;
		logic probe_next;
		logic finish;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic crc_last;
		logic rd_hit;
		logic wrapped;
	} stat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] v;
		v = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

endpackage

/* src/chpi_ctrl.sv */
module chpi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output chpi_pkg::cmd_t cmd,
	input  chpi_pkg::stat_t stat
);
	import chpi_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_CRC, ST_HOME, ST_READ, ST_CHECK, ST_DONE} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.crc_step = (state_q == ST_CRC);
		cmd.probe_start = (state_q == ST_HOME);
		cmd.probe_next = (state_q == ST_CHECK) && !stat.rd_hit && !stat.wrapped;
		cmd.finish = (state_q == ST_CHECK) && (stat.rd_hit || stat.wrapped);
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_CRC;
				ST_CRC: if (stat.crc_last) state_q <= ST_HOME;
				ST_HOME: state_q <= ST_READ;
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (stat.rd_hit || stat.wrapped) state_q <= ST_DONE;
					else state_q <= ST_READ;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* src/chpi_dp.sv */
module chpi_dp #(
	parameter int TABLE_SLOTS = chpi_pkg::TABLE_SLOTS_DEF,
	parameter int NAME_BYTES = chpi_pkg::NAME_BYTES_DEF,
	parameter int TYPE_BYTES = chpi_pkg::TYPE_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  chpi_pkg::req_t  req,
	input  logic [3:0]      size_log2,
	input  chpi_pkg::cmd_t  cmd,
	output chpi_pkg::stat_t stat,
	output logic            result_valid,
	output chpi_pkg::rsp_t  result
);
	import chpi_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int NB = 4 + TYPE_BYTES + NAME_BYTES;
	localparam int BW = $clog2(NB + 1);

	logic        insert_q, idkey_q;
	logic [23:0] tval_q;
	logic [63:0] nval_q;
	logic [31:0] rid_q;
	logic [7:0]  ent_q;
	logic [8*NB-1:0] bytes_q;
	logic [BW-1:0]   nbytes_q, bcnt_q;
	logic [31:0]     crc_q;
	logic [AW-1:0]   mask_q, home_q, idx_q, steps_q;

	logic [23:0] tcan;
	logic [63:0] ncan;
	logic [1:0]  tlen;
	logic [3:0]  nlen;
	logic [3:0]  eff_lg;
	logic [AW-1:0] mask_c;

	// Canonical strings: clamp length, stop at first zero byte.
	always_comb begin
		logic tstop, nstop;
		tcan = '0; ncan = '0; tlen = '0; nlen = '0;
		tstop = 1'b0; nstop = 1'b0;
		for (int n = 0; n < TYPE_BYTES; n++) begin
			if (!tstop && n < int'(req.type_len) && req.type_chars[8*n +: 8] != 8'd0) begin
				tcan[8*n +: 8] = req.type_chars[8*n +: 8];
				tlen = 2'(n + 1);
			end else begin
				tstop = 1'b1;
			end
		end
		for (int n = 0; n < NAME_BYTES; n++) begin
			if (!nstop && n < int'(req.name_len) && req.name_chars[8*n +: 8] != 8'd0) begin
				ncan[8*n +: 8] = req.name_chars[8*n +: 8];
				nlen = 4'(n + 1);
			end else begin
				nstop = 1'b1;
			end
		end
	end

	always_comb begin
		eff_lg = (size_log2 == 4'd0) ? 4'd1 : size_log2;
		if (int'(eff_lg) > AW) eff_lg = 4'(AW);
		mask_c = AW'((32'd1 << eff_lg) - 32'd1);
	end

	// Valid bits and key stores.
	logic [TABLE_SLOTS-1:0] nvalid_q, ivalid_q;
	logic [63:0] nkey_mem [TABLE_SLOTS];
	logic [23:0] ntype_mem [TABLE_SLOTS];
	logic [7:0]  nent_mem [TABLE_SLOTS];
	logic [31:0] ikey_mem [TABLE_SLOTS];
	logic [23:0] itype_mem [TABLE_SLOTS];
	logic [7:0]  ient_mem [TABLE_SLOTS];
	logic [63:0] rd_nkey_q;
	logic [23:0] rd_ntype_q, rd_itype_q;
	logic [7:0]  rd_nent_q, rd_ient_q;
	logic [31:0] rd_ikey_q;
	logic        rd_nv_q, rd_iv_q;

	logic rd_valid, rd_match, do_write;
	assign rd_valid = idkey_q ? rd_iv_q : rd_nv_q;
	assign rd_match = idkey_q ? (rd_itype_q == tval_q && rd_ikey_q == rid_q)
		: (rd_ntype_q == tval_q && rd_nkey_q == nval_q);
	assign stat.rd_hit = !rd_valid || rd_match;
	assign stat.wrapped = (steps_q == mask_q);
	assign stat.crc_last = (bcnt_q + BW'(1) >= nbytes_q) || (nbytes_q == '0);
	assign do_write = cmd.finish && stat.rd_hit && insert_q;

	always_ff @(posedge clk) begin
		rd_nkey_q <= nkey_mem[idx_q];
		rd_ntype_q <= ntype_mem[idx_q];
		rd_nent_q <= nent_mem[idx_q];
		rd_ikey_q <= ikey_mem[idx_q];
		rd_itype_q <= itype_mem[idx_q];
		rd_ient_q <= ient_mem[idx_q];
		if (do_write && !idkey_q) begin
			nkey_mem[idx_q] <= nval_q;
			ntype_mem[idx_q] <= tval_q;
			nent_mem[idx_q] <= ent_q;
		end
		if (do_write && idkey_q) begin
			ikey_mem[idx_q] <= rid_q;
			itype_mem[idx_q] <= tval_q;
			ient_mem[idx_q] <= ent_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvalid_q <= '0;
			ivalid_q <= '0;
			rd_nv_q <= 1'b0;
			rd_iv_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			rd_nv_q <= nvalid_q[idx_q];
			rd_iv_q <= ivalid_q[idx_q];
			if (do_write && !idkey_q) nvalid_q[idx_q] <= 1'b1;
			if (do_write && idkey_q) ivalid_q[idx_q] <= 1'b1;
			result_valid <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			insert_q <= (req.req_type == REQ_INSERT);
			idkey_q <= (req.key_kind == KEY_ID);
			tval_q <= tcan;
			nval_q <= ncan;
			rid_q <= req.res_id;
			ent_q <= req.entry_index;
			mask_q <= mask_c;
			bcnt_q <= '0;
			crc_q <= 32'hFFFFFFFF;
			if (req.key_kind == KEY_ID) begin
				bytes_q <= (8*NB)'({tcan[8*TYPE_BYTES-1:0], req.res_id});
				nbytes_q <= BW'(4) + BW'(tlen);
			end else begin
				// The name bytes follow the valid type bytes with no gap.
				bytes_q <= (8*NB)'(tcan[8*TYPE_BYTES-1:0])
					| ((8*NB)'(ncan[8*NAME_BYTES-1:0]) << (8 * int'(tlen)));
				nbytes_q <= BW'(tlen) + BW'(nlen);
			end
		end
		if (cmd.crc_step && nbytes_q != '0) begin
			crc_q <= crc_byte(crc_q, bytes_q[7:0]);
			bytes_q <= bytes_q >> 8;
			bcnt_q <= bcnt_q + BW'(1);
		end
		if (cmd.probe_start) begin
			home_q <= AW'(~crc_q) & mask_q;
			idx_q <= AW'(~crc_q) & mask_q;
			steps_q <= '0;
		end
		if (cmd.probe_next) begin
			idx_q <= (idx_q + AW'(1)) & mask_q;
			steps_q <= steps_q + AW'(1);
		end
		if (cmd.finish) begin
			if (stat.rd_hit) begin
				result.found <= rd_valid;
				result.slot <= 8'(idx_q);
				result.found_entry <= rd_valid ? (idkey_q ? rd_ient_q : rd_nent_q) : 8'd0;
				result.table_full <= 1'b0;
			end else begin
				result.found <= 1'b0;
				result.slot <= 8'(home_q);
				result.found_entry <= 8'd0;
				result.table_full <= 1'b1;
			end
		end
	end
endmodule

/* src/crc_hashed_linear_probe_index.sv */
// One request is taken when start is high and busy is low. The block first runs a byte-serial
// CRC-32 over the key (one key byte at a time, up to 11 bytes; an empty key still passes the CRC state),
// then walks the table one slot at a time, each slot through the registered read of the slot store,
// and finally presents one result for a single cycle on done; the receiver cannot stall it, so
// it must capture the result then. The block takes no new request until it is idle again after
// its result. Valid bits clear at reset.
module crc_hashed_linear_probe_index #(
	parameter int TABLE_SLOTS = chpi_pkg::TABLE_SLOTS_DEF,
	parameter int NAME_BYTES = chpi_pkg::NAME_BYTES_DEF,
	parameter int TYPE_BYTES = chpi_pkg::TYPE_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  chpi_pkg::req_t req,
	output logic           done,
	output chpi_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [1:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import chpi_pkg::*;

	logic [3:0] size_log2_q;
	cmd_t cmd;
	stat_t stat;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_log2_q <= SIZE_LOG2_RESET;
		else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
			size_log2_q <= pwdata[3:0];
	end
	assign prdata = (paddr == 2'd0) ? {28'd0, size_log2_q} : 32'd0;

	chpi_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd, .stat);

	chpi_dp #(.TABLE_SLOTS(TABLE_SLOTS), .NAME_BYTES(NAME_BYTES), .TYPE_BYTES(TYPE_BYTES))
	u_dp (.clk, .arst_n, .req, .size_log2(size_log2_q), .cmd, .stat,
		.result_valid(done), .result(rsp));

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(start && !busy))
		else $error("result too soon after request");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result repeated");
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.table_full |-> !rsp.found && rsp.found_entry == 8'd0)
		else $error("full result carries a match");
endmodule

/* tb/sv/crc_hashed_linear_probe_index_checker.sv */
module crc_hashed_linear_probe_index_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  chpi_pkg::req_t req,
	input  logic           done,
	input  chpi_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [1:0]     paddr,
	input  logic [31:0]    pwdata,
	input  logic           pready,
	output int             errors,
	output int             pending
);
	import chpi_pkg::*;

	logic [3:0] size_log2_q;
	bit         nm_valid [256];
	logic [63:0] nm_name [256];
	logic [23:0] nm_type [256];
	logic [7:0]  nm_entry [256];
	bit         id_valid [256];
	logic [31:0] id_key [256];
	logic [23:0] id_type [256];
	logic [7:0]  id_entry [256];
	rsp_t       expected_rsp_q [$];

	assign pending = expected_rsp_q.size();

	// Clamp the length and cut the string at its first zero byte.
	function automatic logic [63:0] trim_string(input logic [63:0] chars, input int len,
			input int maxlen, output int eff);
		logic [63:0] v;
		v = '0;
		eff = 0;
		if (len > maxlen) begin
			len = maxlen;
		end
		while (eff < len && chars[8*eff +: 8] != 8'd0) begin
			v[8*eff +: 8] = chars[8*eff +: 8];
			eff++;
		end
		return v;
	endfunction

	function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [63:0] v,
			input int n);
		for (int i = 0; i < n; i++) begin
			c ^= {24'd0, v[8*i +: 8]};
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
			end
		end
		return c;
	endfunction

	task automatic probe_index(input req_t r, output rsp_t o);
		logic [23:0] tv;
		logic [63:0] nv;
		logic [31:0] c;
		int tl, nl, lg, sz, home, i;
		bit hit, fnd;
		tv = 24'(trim_string({40'd0, r.type_chars}, r.type_len, 3, tl));
		nv = trim_string(r.name_chars, r.name_len, 8, nl);
		lg = size_log2_q;
		if (lg < 1) begin
			lg = 1;
		end
		if (lg > 8) begin
			lg = 8;
		end
		sz = 1 << lg;
		c = 32'hFFFFFFFF;
		if (r.key_kind == KEY_ID) begin
			c = crc_feed(c, {32'd0, r.res_id}, 4);
			c = crc_feed(c, {40'd0, tv}, tl);
		end else begin
			c = crc_feed(c, {40'd0, tv}, tl);
			c = crc_feed(c, nv, nl);
		end
		c = ~c;
		home = c & (sz - 1);
		i = home;
		hit = 0;
		fnd = 0;
		for (int s = 0; s < sz && !hit; s++) begin
			if (r.key_kind == KEY_ID) begin
				if (!id_valid[i]) begin
					hit = 1;
				end else if (id_type[i] == tv && id_key[i] == r.res_id) begin
					hit = 1;
					fnd = 1;
				end
			end else begin
				if (!nm_valid[i]) begin
					hit = 1;
				end else if (nm_type[i] == tv && nm_name[i] == nv) begin
					hit = 1;
					fnd = 1;
				end
			end
			if (!hit) begin
				i = (i + 1) & (sz - 1);
			end
		end
		if (!hit) begin
			o = '{found: 1'b0, slot: home[7:0], found_entry: 8'd0, table_full: 1'b1};
		end else begin
			o.found = fnd;
			o.slot = i[7:0];
			o.found_entry = !fnd ? 8'd0 : (r.key_kind == KEY_ID ? id_entry[i] : nm_entry[i]);
			o.table_full = 1'b0;
			if (r.req_type == REQ_INSERT) begin
				if (r.key_kind == KEY_ID) begin
					id_valid[i] = 1;
					id_key[i] = r.res_id;
					id_type[i] = tv;
					id_entry[i] = r.entry_index;
				end else begin
					nm_valid[i] = 1;
					nm_name[i] = nv;
					nm_type[i] = tv;
					nm_entry[i] = r.entry_index;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			size_log2_q <= SIZE_LOG2_RESET;
			for (int s = 0; s < 256; s++) begin
				nm_valid[s] = 0;
				id_valid[s] = 0;
			end
			expected_rsp_q.delete();
			errors <= 0;
		end else begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) begin
						$display("Unexpected result %p", rsp);
					end
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp.found !== exp_rsp.found || rsp.slot !== exp_rsp.slot ||
							rsp.found_entry !== exp_rsp.found_entry ||
							rsp.table_full !== exp_rsp.table_full) begin
						errors <= errors + 1;
						if (errors < 10) begin
							$display("Result mismatch: expected %p, got %p", exp_rsp, rsp);
						end
					end
				end
			end
			if (start && !busy) begin
				probe_index(req, exp_rsp);
				expected_rsp_q.push_back(exp_rsp);
			end
			if (psel && penable && pwrite && pready && paddr == 2'(4 * REG_SIZE_LOG2)) begin
				size_log2_q <= pwdata[3:0];
			end
		end
	end
endmodule

/* tb/sv/crc_hashed_linear_probe_index_tb.sv */
module crc_hashed_linear_probe_index_tb;
	import chpi_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	int          quiet_cycles;
	bit          no_gaps;

	logic [23:0] type_pool [4] = '{24'h545352, 24'h004D53, 24'h41, 24'h4E4942};
	logic [63:0] name_pool [6] = '{64'h0059_4C4C_4942, 64'h4142_4344_4546_4748,
		64'h0041, 64'h4142_0043_4400_4546, 64'hFFFF_FFFF_FFFF_FFFF, 64'h3130_3932};
	logic [31:0] id_pool [6] = '{32'd0, 32'd1, 32'd1000, 32'hFFFFFFFF, 32'h80000000, 32'd77};

	crc_hashed_linear_probe_index dut (.*);

	crc_hashed_linear_probe_index_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Watchdog: cycles with no request accepted, no result and no register access.
	always @(posedge clk) begin
		if ((start && !busy) || done || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles > 6000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_request(input req_t r);
		int gap;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		gap = $urandom_range(99);
		if (no_gaps || gap < 65) begin
			gap = 0;
		end else if (gap < 94) begin
			gap = $urandom_range(3, 1);
		end else begin
			gap = $urandom_range(60, 15);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_requests();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_size(input logic [3:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 2'(4 * REG_SIZE_LOG2);
		pwdata <= {28'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic req_t make_request();
		req_t r;
		r.req_type = 1'($urandom_range(1));
		r.key_kind = 1'($urandom_range(1));
		r.type_chars = $urandom_range(99) < 80 ? type_pool[$urandom_range(3)] :
			24'($urandom);
		r.type_len = $urandom_range(99) < 70 ? 2'd3 : 2'($urandom_range(3));
		r.name_chars = $urandom_range(99) < 75 ? name_pool[$urandom_range(5)] :
			{$urandom, $urandom};
		if ($urandom_range(9) == 0) begin
			r.name_chars[8*$urandom_range(7) +: 8] = 8'd0;
		end
		r.name_len = $urandom_range(99) < 70 ? 4'd8 : 4'($urandom_range(15));
		r.res_id = $urandom_range(99) < 75 ? id_pool[$urandom_range(5)] : $urandom;
		r.entry_index = 8'($urandom);
		return r;
	endfunction

	initial begin
		req_t r;
		logic [3:0] sizes [7] = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd2, 4'd3, 4'd6};
		arst_n = 0;
		start = 0;
		req = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		no_gaps = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed requests at the reset size.
		r = '{REQ_LOOKUP, KEY_NAME, 24'h545352, 2'd3, 64'h0059_4C4C_4942, 4'd8, 32'd0, 8'd0};
		send_request(r);
		r.req_type = REQ_INSERT;
		r.entry_index = 8'd5;
		send_request(r);
		r.req_type = REQ_LOOKUP;
		send_request(r);
		// Insert on a key that is already present overwrites its entry.
		r.req_type = REQ_INSERT;
		r.entry_index = 8'hFF;
		send_request(r);
		// Same name with garbage past the zero byte and a clamped length.
		r.name_chars = 64'hAB00_0059_4C4C_4942;
		r.name_len = 4'd15;
		r.req_type = REQ_LOOKUP;
		send_request(r);
		r = '{REQ_INSERT, KEY_ID, 24'hFFFFFF, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15,
			32'hFFFFFFFF, 8'hAA};
		send_request(r);
		// Id keys ignore the name field.
		r.name_chars = '0;
		r.name_len = 4'd0;
		r.req_type = REQ_LOOKUP;
		send_request(r);
		r = '0;
		send_request(r);
		r.req_type = REQ_INSERT;
		send_request(r);
		r.key_kind = KEY_ID;
		send_request(r);
		send_request(r);
		r = '{REQ_INSERT, KEY_NAME, 24'h00FF41, 2'd0, 64'h41, 4'd1, 32'd9, 8'd1};
		send_request(r);
		r.type_len = 2'd3;
		send_request(r);
		drain_requests();

		// A two-slot table fills quickly and then reports full.
		write_size(4'd1);
		for (int k = 0; k < 4; k++) begin
			r = '{REQ_INSERT, KEY_ID, 24'h41, 2'd1, 64'd0, 4'd0, 32'(k + 100), 8'(k)};
			send_request(r);
		end
		drain_requests();

		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				write_size(sizes[p - 1]);
			end
			for (int n = 0; n < 200; n++) begin
				if (n % 50 == 0) begin
					no_gaps = $urandom_range(3) == 0;
				end
				send_request(make_request());
			end
			drain_requests();
		end
		write_size(4'd4);
		for (int n = 0; n < 30; n++) begin
			send_request(make_request());
		end
		drain_requests();

		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

/* filelist.f */
src/chpi_pkg.sv
src/chpi_ctrl.sv
src/chpi_dp.sv
src/crc_hashed_linear_probe_index.sv
tb/sv/crc_hashed_linear_probe_index_checker.sv
tb/sv/crc_hashed_linear_probe_index_tb.sv
